// File: rtl/tsl_pkg.sv
package tsl_pkg;

   localparam int DEPTH_DEF      = 16;
   localparam int DATA_WIDTH_DEF = 32;

   localparam int OP_W        = 2;
   localparam int VALUE_W     = 32;
   localparam int POS_W       = 5;
   localparam int STATUS_W    = 2;
   localparam int INDEX_W     = 4;
   localparam int COUNT_W     = 5;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 48;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND      = 2'd0,
      OP_READ_NTH    = 2'd1,
      OP_SEARCH      = 2'd2,
      OP_SEARCH_SWAP = 2'd3
   } tsl_op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2
   } tsl_status_type;

   typedef struct packed {
      tsl_status_type      status;
      logic [INDEX_W-1:0]  index;
      logic [VALUE_W-1:0]  entry_value;
      logic [COUNT_W-1:0]  entry_count;
   } tsl_rsp_type;

endpackage

// File: rtl/tsl_mem.sv
module tsl_mem #(
   parameter int DEPTH      = tsl_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = tsl_pkg::DATA_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [DATA_WIDTH-1:0]      wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [DATA_WIDTH-1:0]      rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/tsl_ctrl.sv
module tsl_ctrl #(
   parameter int DEPTH      = tsl_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = tsl_pkg::DATA_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  tsl_pkg::tsl_op_type                req_op,
   input  logic [tsl_pkg::VALUE_W-1:0]        req_value,
   input  logic [tsl_pkg::POS_W-1:0]          req_position,
   output logic                               res_valid,
   input  logic                               res_ready,
   output tsl_pkg::tsl_rsp_type               res,
   output logic                               wr_en,
   output logic [$clog2(DEPTH)-1:0]           wr_addr,
   output logic [DATA_WIDTH-1:0]              wr_data,
   output logic                               rd_en,
   output logic [$clog2(DEPTH)-1:0]           rd_addr,
   input  logic [DATA_WIDTH-1:0]              rd_data
);
   import tsl_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_READ = 5'b00010,
      ST_SRCH = 5'b00100,
      ST_SWAP = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   tsl_op_type            op_ff, op_in;
   logic [DATA_WIDTH-1:0] key_ff, key_in;
   logic [DATA_WIDTH-1:0] prev_ff, prev_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   tsl_rsp_type           res_ff, res_in;
   logic [DATA_WIDTH-1:0] req_word;
   logic                  pos_ok;

   // Only the low DATA_WIDTH bits of a value are stored and compared.
   assign req_word = DATA_WIDTH'($unsigned(req_value));
   assign pos_ok   = (req_position != '0)
                  && (CMP_W'(req_position) <= CMP_W'(count_ff));

   assign req_ready = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);

   always_comb begin
      res             = res_ff;
      res.entry_count = COUNT_W'(count_ff);
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      op_in    = op_ff;
      key_in   = key_ff;
      prev_in  = prev_ff;
      idx_in   = idx_ff;
      res_in   = res_ff;
      wr_en    = 1'b0;
      wr_addr  = '0;
      wr_data  = '0;
      rd_en    = 1'b0;
      rd_addr  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in  = req_op;
               key_in = req_word;
               res_in = '{status: STATUS_NOT_FOUND, index: '0, entry_value: '0,
                          entry_count: '0};
               unique case (req_op)
                  OP_APPEND: begin
                     if (count_ff == CNT_W'(DEPTH)) begin
                        res_in.status = STATUS_FULL;
                     end else begin
                        wr_en         = 1'b1;
                        wr_addr       = IDX_W'(count_ff);
                        wr_data       = req_word;
                        res_in.status = STATUS_OK;
                        res_in.index  = INDEX_W'(count_ff);
                        count_in      = count_ff + CNT_W'(1);
                     end
                     state_in = ST_DONE;
                  end
                  OP_READ_NTH: begin
                     if (pos_ok) begin
                        rd_en    = 1'b1;
                        rd_addr  = IDX_W'(req_position - POS_W'(1));
                        idx_in   = IDX_W'(req_position - POS_W'(1));
                        state_in = ST_READ;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  OP_SEARCH, OP_SEARCH_SWAP: begin
                     if (count_ff == '0) begin
                        state_in = ST_DONE;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        idx_in   = '0;
                        state_in = ST_SRCH;
                     end
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_READ: begin
            res_in.status      = STATUS_OK;
            res_in.index       = INDEX_W'(idx_ff);
            res_in.entry_value = VALUE_W'(rd_data);
            state_in           = ST_DONE;
         end
         ST_SRCH: begin
            // rd_data holds entry idx_ff; prev_ff holds the entry before it.
            priority if (rd_data == key_ff) begin
               res_in.status = STATUS_OK;
               if (op_ff == OP_SEARCH_SWAP && idx_ff != '0) begin
                  wr_en        = 1'b1;
                  wr_addr      = idx_ff;
                  wr_data      = prev_ff;
                  res_in.index = INDEX_W'(idx_ff - IDX_W'(1));
                  state_in     = ST_SWAP;
               end else begin
                  res_in.index = INDEX_W'(idx_ff);
                  state_in     = ST_DONE;
               end
            end else if (CNT_W'(idx_ff) + CNT_W'(1) == count_ff) begin
               state_in = ST_DONE;
            end else begin
               prev_in  = rd_data;
               idx_in   = idx_ff + IDX_W'(1);
               rd_en    = 1'b1;
               rd_addr  = idx_ff + IDX_W'(1);
            end
         end
         ST_SWAP: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff - IDX_W'(1);
            wr_data  = key_ff;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      op_ff   <= op_in;
      key_ff  <= key_in;
      prev_ff <= prev_in;
      idx_ff  <= idx_in;
      res_ff  <= res_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count exceeds depth");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SRCH) |-> (CNT_W'(idx_ff) < count_ff))
      else $error("search walked past the last entry");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en && wr_addr == rd_addr))
      else $error("read and write of the same entry in one cycle");

   a_append_counts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_op == OP_APPEND && count_ff != CNT_W'(DEPTH))
      |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("append did not advance the entry count");

endmodule

// File: rtl/tsl_out.sv
module tsl_out (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  tsl_pkg::tsl_rsp_type  in_rsp,
   output logic                  out_valid,
   input  logic                  out_ready,
   output tsl_pkg::tsl_rsp_type  out_rsp
);
   import tsl_pkg::*;

   logic        valid_ff, valid_in;
   tsl_rsp_type rsp_ff, rsp_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      rsp_in   = rsp_ff;
      if (in_ready) begin
         valid_in = in_valid;
         if (in_valid) begin
            rsp_in = in_rsp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign out_valid = valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

// File: rtl/transpose_search_list_unit.sv
// Ordered list of up to DEPTH words kept in one synchronous RAM with an entry
// count; each item appends, reads the nth entry, searches, or searches and
// moves the match one place toward the head. Items are handled one at a time:
// append writes the RAM directly, read nth issues one RAM read and captures
// the word (an out-of-range position reads nothing), and a search reads the
// entries one by one (one RAM read per entry examined, at most DEPTH), plus a
// second write for a transpose swap. A finished result sits in an output
// register, so the next item is accepted while it waits. The RAM needs no
// clearing after reset, since only entries below the count are read.
module transpose_search_list_unit #(
   parameter int DEPTH      = tsl_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = tsl_pkg::DATA_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [31:0] value, [36:32] position, [39:37] zero
   input  logic [tsl_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // [1:0] operation
   input  logic [tsl_pkg::OP_W-1:0]           req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [3:0] index, [35:4] entry_value, [40:36] entry_count, [47:41] zero
   output logic [tsl_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // [1:0] status
   output logic [tsl_pkg::STATUS_W-1:0]       rsp_tuser
);
   import tsl_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);

   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;
   logic                  res_valid;
   logic                  res_ready;
   tsl_rsp_type           res;
   tsl_rsp_type           out_rsp;

   tsl_mem #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tsl_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_op       (tsl_op_type'(req_tuser)),
      .req_value    (req_tdata[VALUE_W-1:0]),
      .req_position (req_tdata[VALUE_W+POS_W-1:VALUE_W]),
      .res_valid    (res_valid),
      .res_ready    (res_ready),
      .res          (res),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data)
   );

   tsl_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_ready  (res_ready),
      .in_rsp    (res),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rsp   (out_rsp)
   );

   assign rsp_tdata = {(RSP_TDATA_W - INDEX_W - VALUE_W - COUNT_W)'(0),
                       out_rsp.entry_count, out_rsp.entry_value, out_rsp.index};
   assign rsp_tuser = out_rsp.status;

endmodule
